// File: rtl/four_direction_edge_filter_top_defines.svh
// ----------------------------------------------------------------------------
// four_direction_edge_filter_top_defines
// assertion macros shared by the edge filter rtl, clocked on clk, held off in rst
// ----------------------------------------------------------------------------
`ifndef FOUR_DIRECTION_EDGE_FILTER_TOP_DEFINES_SVH
`define FOUR_DIRECTION_EDGE_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define FDEF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdef check failed");

// next-cycle implication
`define FDEF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdef check failed");

`endif

// File: rtl/fdef_pkg.sv
// ----------------------------------------------------------------------------
// fdef_pkg
// types, constants and kernel arithmetic for the four-direction edge filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdef_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CFG_W       = 9;
  localparam int PIX_W       = 8;
  localparam int RESP_W      = 12;
  localparam int VAL_W       = 13;
  localparam int DIR_COUNT   = 4;
  localparam int TAP_NUM     = 9;
  localparam int WIDTH_MIN   = 3;
  localparam int WIDTH_RESET = 224;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // taps 0..2 right column, 3..5 centre, 6..8 left; each column top to bottom
  localparam int KERNEL [DIR_COUNT][TAP_NUM] = '{
    '{-1,  0,  1, -2,  0,  2, -1,  0,  1},
    '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
    '{ 0,  1,  2, -1,  0,  1, -2, -1,  0},
    '{ 2,  1,  0,  1,  0,  1,  0, -1, -2}
  };

  typedef logic [PIX_W-1:0]         pixel_t;
  typedef logic [COL_W-1:0]         col_t;
  typedef logic signed [RESP_W-1:0] resp_t;
  typedef logic [VAL_W-1:0]         val_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } line_word_t;

  // control travelling down the pipeline with each item
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
    logic op;
  } job_t;

  function automatic resp_t kernel_resp(input int k, input column_t lf,
                                        input column_t ct, input column_t rt);
    int tap [TAP_NUM];
    int acc;
    tap[0] = int'(rt.top);
    tap[1] = int'(rt.mid);
    tap[2] = int'(rt.bot);
    tap[3] = int'(ct.top);
    tap[4] = int'(ct.mid);
    tap[5] = int'(ct.bot);
    tap[6] = int'(lf.top);
    tap[7] = int'(lf.mid);
    tap[8] = int'(lf.bot);
    acc = 0;
    for (int t = 0; t < TAP_NUM; t++) begin
      acc += KERNEL[k][t] * tap[t];
    end
    return RESP_W'(acc);
  endfunction

  function automatic val_t mag(input resp_t r);
    logic [RESP_W-1:0] u;
    u = r[RESP_W-1] ? unsigned'(-r) : unsigned'(r);
    return VAL_W'(u);
  endfunction

endpackage

// File: rtl/fdef_line_ram.sv
// ----------------------------------------------------------------------------
// fdef_line_ram
// line buffer store, one word per column holding the two previous rows
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdef_line_ram (
  input  logic                clk,
  input  logic                we,
  input  fdef_pkg::col_t      waddr,
  input  fdef_pkg::line_word_t wdata,
  input  logic                re,
  input  fdef_pkg::col_t      raddr,
  output fdef_pkg::line_word_t rdata
);

  fdef_pkg::line_word_t mem [fdef_pkg::MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fdef_window.sv
// ----------------------------------------------------------------------------
// fdef_window
// 3x3 window registers, four kernel responses and absolute sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdef_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  fdef_pkg::job_t     in_job,
  input  logic               col_zero,
  input  fdef_pkg::column_t  new_col,
  output fdef_pkg::job_t     out_job,
  output fdef_pkg::val_t     sum_a,
  output fdef_pkg::val_t     sum_b
);

  fdef_pkg::column_t win [3];
  fdef_pkg::job_t    win_job;
  fdef_pkg::resp_t   resp_a [fdef_pkg::DIR_COUNT];
  fdef_pkg::resp_t   resp_b [fdef_pkg::DIR_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      win_job <= '0;
      out_job <= '0;
    end else if (adv) begin
      win_job <= in_job;
      out_job <= win_job;
    end
  end

  // window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (adv && in_job.valid) begin
      if (col_zero) begin
        win[0] <= '0;
        win[1] <= '0;
      end else begin
        win[0] <= win[1];
        win[1] <= win[2];
      end
      win[2] <= new_col;
    end
  end

  // second set is the right-edge output with a zero column beyond the frame
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < fdef_pkg::DIR_COUNT; k++) begin
        resp_a[k] <= fdef_pkg::kernel_resp(k, win[0], win[1], win[2]);
        resp_b[k] <= fdef_pkg::kernel_resp(k, win[1], win[2], '0);
      end
    end
  end

  assign sum_a = fdef_pkg::mag(resp_a[0]) + fdef_pkg::mag(resp_a[1])
               + fdef_pkg::mag(resp_a[2]) + fdef_pkg::mag(resp_a[3]);
  assign sum_b = fdef_pkg::mag(resp_b[0]) + fdef_pkg::mag(resp_b[1])
               + fdef_pkg::mag(resp_b[2]) + fdef_pkg::mag(resp_b[3]);

endmodule

// File: rtl/fdef_out_buf.sv
// ----------------------------------------------------------------------------
// fdef_out_buf
// output register holding up to two results of one item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdef_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  fdef_pkg::job_t job,
  input  fdef_pkg::val_t sum_a,
  input  fdef_pkg::val_t sum_b,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_ready,
  output fdef_pkg::val_t edge_value,
  output logic           last_of_run,
  output logic           frame_end
);

  logic [1:0]     cnt;
  logic           fe;
  fdef_pkg::val_t head;
  fdef_pkg::val_t tail;
  logic           load;
  logic           take;

  assign out_valid   = (cnt != 2'd0);
  assign take        = out_valid && out_ready;
  // room when empty, when the only waiting result leaves this cycle, or when
  // the item at the end of the pipeline has nothing to load
  assign adv         = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready)
                     || !(job.valid && job.emit);
  assign load        = adv && job.valid && job.emit;
  assign edge_value  = head;
  assign last_of_run = (cnt == 2'd1);
  assign frame_end   = (cnt == 2'd1) && fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      fe  <= 1'b0;
    end else if (load) begin
      cnt <= job.last ? 2'd2 : 2'd1;
      fe  <= job.last && (job.op == fdef_pkg::OP_FLUSH);
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= sum_a;
      tail <= sum_b;
    end else if (take) begin
      head <= tail;
    end
  end

endmodule

// File: rtl/four_direction_edge_filter_top.sv
// ----------------------------------------------------------------------------
// four_direction_edge_filter_top
// 3x3 four-direction edge magnitude over a raster pixel stream
//
// pixels arrive on the in channel (op, pixel) one transfer per clock, row by
// row, frame_width per row; a trailing row of flush items (op = 1) closes the
// frame. each transfer at row r >= 1, column c >= 1 yields output (r-1, c-1)
// on the out channel; the last column of a row yields a second one, the right
// edge output. last_of_run marks the final result of a transfer, frame_end
// the final output of the frame.
// one transfer per clock while out_ready is held high; the second result of a
// row end leaves while the column-0 item behind it, which has no result, moves
// through. an input transfer reaches out_valid through the line buffer read
// with the transfer, then window update, kernel responses, output register.
// frame_width is written over the cfg channel (always ready); the user must
// write it only while idle, the block does not enforce this. reset clears the
// counters and pipeline and sets frame_width to 224; the line buffer holds no
// reset state. when the receiver stalls, the output register holds its results
// and in_ready drops once the next item has a result to load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_direction_edge_filter_top_defines.svh"

module four_direction_edge_filter_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fdef_pkg::CFG_W-1:0]  frame_width,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  fdef_pkg::pixel_t            pixel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fdef_pkg::val_t              edge_value,
  output logic                        last_of_run,
  output logic                        frame_end
);

  logic [fdef_pkg::CFG_W-1:0] width_reg;
  fdef_pkg::col_t             last_col;
  fdef_pkg::col_t             col;
  logic [1:0]                 rows_seen;
  logic                       accept;
  logic                       is_last;
  logic                       adv;

  logic                       s1_valid;
  fdef_pkg::col_t             s1_col;
  logic                       s1_last;
  logic                       s1_op;
  fdef_pkg::pixel_t           s1_pix;
  logic                       s1_rge1;
  logic                       s1_rge2;

  logic                       ram_we;
  logic                       ram_re;
  fdef_pkg::col_t             ram_waddr;
  fdef_pkg::col_t             ram_raddr;
  fdef_pkg::line_word_t       ram_wdata;
  fdef_pkg::line_word_t       ram_rdata;

  fdef_pkg::job_t             s1_job;
  fdef_pkg::column_t          new_col;
  fdef_pkg::job_t             c_job;
  fdef_pkg::val_t             sum_a;
  fdef_pkg::val_t             sum_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= fdef_pkg::CFG_W'(fdef_pkg::WIDTH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      width_reg <= frame_width;
    end
  end

  // effective width held within 3..MAX_WIDTH
  always_comb begin
    if (width_reg < fdef_pkg::CFG_W'(fdef_pkg::WIDTH_MIN)) begin
      last_col = fdef_pkg::COL_W'(fdef_pkg::WIDTH_MIN - 1);
    end else if (32'(width_reg) >= fdef_pkg::MAX_WIDTH) begin
      last_col = fdef_pkg::COL_W'(fdef_pkg::MAX_WIDTH - 1);
    end else begin
      last_col = fdef_pkg::COL_W'(width_reg - fdef_pkg::CFG_W'(1));
    end
  end

  assign in_ready = adv;
  assign accept   = in_valid && in_ready;
  assign is_last  = (col >= last_col);

  // rows_seen saturates at two: only r >= 1 and r >= 2 matter
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      rows_seen <= 2'd0;
    end else if (accept) begin
      if (is_last) begin
        col <= '0;
        if (op == fdef_pkg::OP_FLUSH) begin
          rows_seen <= 2'd0;
        end else if (rows_seen != 2'd2) begin
          rows_seen <= rows_seen + 2'd1;
        end
      end else begin
        col <= col + fdef_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col  <= col;
      s1_last <= is_last;
      s1_op   <= op;
      s1_pix  <= (op == fdef_pkg::OP_FLUSH) ? '0 : pixel;
      s1_rge1 <= (rows_seen != 2'd0);
      s1_rge2 <= (rows_seen == 2'd2);
    end
  end

  // read at the transfer, write back one stage later; the column always moves
  // on between them, so the two ports never meet on one entry
  assign ram_re    = accept;
  assign ram_raddr = col;
  assign ram_we    = adv && s1_valid;
  assign ram_waddr = s1_col;

  assign new_col.top = s1_rge2 ? ram_rdata.upper : '0;
  assign new_col.mid = s1_rge1 ? ram_rdata.lower : '0;
  assign new_col.bot = s1_pix;

  assign ram_wdata.upper = new_col.mid;
  assign ram_wdata.lower = s1_pix;

  assign s1_job.valid = s1_valid;
  assign s1_job.emit  = s1_rge1 && (s1_col != '0);
  assign s1_job.last  = s1_last;
  assign s1_job.op    = s1_op;

  fdef_line_ram u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fdef_window u_window (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_job   (s1_job),
    .col_zero (s1_col == '0),
    .new_col  (new_col),
    .out_job  (c_job),
    .sum_a    (sum_a),
    .sum_b    (sum_b)
  );

  fdef_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .job         (c_job),
    .sum_a       (sum_a),
    .sum_b       (sum_b),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edge_value  (edge_value),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

  `FDEF_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr)
  `FDEF_ASSERT_IMP(a_stall_has_cause, !in_ready, out_valid)
  `FDEF_ASSERT_IMP(a_frame_end_closes_run, out_valid && frame_end, last_of_run)
  `FDEF_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run, out_valid)

endmodule

// File: tb/four_direction_edge_filter_top_test.sv
// ----------------------------------------------------------------------------
// four_direction_edge_filter_top_test
// self-checking bench for the four-direction 3x3 edge filter: a queue-fed
// driver streams raster frames (pixel rows closed by a flush row) under random
// gaps and one long output hold-off, a clocked predictor computes every edge
// result from the accepted transfers and a monitor checks each output field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_direction_edge_filter_top_test;
  import fdef_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int ROW_CAP      = 511;
  localparam int RANDOM_ITEMS = 500;

  // taps 0..2 newest column, 3..5 centre, 6..8 oldest; each column top to bottom
  localparam int DIR_TAPS [4][9] = '{
    '{-1,  0,  1, -2,  0,  2, -1,  0,  1},
    '{-1, -2, -1,  0,  0,  0,  1,  2,  1},
    '{ 0,  1,  2, -1,  0,  1, -2, -1,  0},
    '{ 2,  1,  0,  1,  0,  1,  0, -1, -2}
  };

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } pix_col_t;

  typedef struct packed {
    logic   is_flush;
    pixel_t pix;
  } stream_item_t;

  typedef struct packed {
    val_t value;
    logic run_end;
    logic frame_done;
  } edge_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] frame_width = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             op = OP_PIXEL;
  pixel_t           pixel = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  val_t             edge_value;
  logic             last_of_run;
  logic             frame_end;

  four_direction_edge_filter_top uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .frame_width (frame_width),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edge_value  (edge_value),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  stream_item_t pixel_stream [$];
  edge_result_t pending_edges [$];
  int           queued_items = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  logic         in_took = 1'b0;
  logic         steady = 1'b0;
  logic         squeeze = 1'b0;

  // predictor state
  pixel_t           line_prev2 [MAX_WIDTH];
  pixel_t           line_prev1 [MAX_WIDTH];
  pix_col_t         window [3];
  int               col_pos;
  int               row_pos;
  logic [CFG_W-1:0] width_reg;

  function automatic int clamp_width(input int value);
    if (value < WIDTH_MIN) return WIDTH_MIN;
    if (value > MAX_WIDTH) return MAX_WIDTH;
    return value;
  endfunction

  function automatic val_t kernel_total(input pix_col_t lf, input pix_col_t ct,
                                        input pix_col_t rt);
    int tap [9];
    int acc;
    int total;
    tap = '{int'(rt.top), int'(rt.mid), int'(rt.bot),
            int'(ct.top), int'(ct.mid), int'(ct.bot),
            int'(lf.top), int'(lf.mid), int'(lf.bot)};
    total = 0;
    for (int k = 0; k < 4; k++) begin
      acc = 0;
      for (int t = 0; t < 9; t++) begin
        acc += DIR_TAPS[k][t] * tap[t];
      end
      total += (acc < 0) ? -acc : acc;
    end
    return val_t'(total);
  endfunction

  task automatic predict_edges(input logic kind, input pixel_t pix_in);
    pix_col_t     fresh;
    pix_col_t     blank;
    edge_result_t res;
    pixel_t       p;
    int           w;
    bit           at_end;
    p = (kind == OP_FLUSH) ? '0 : pix_in;
    w = clamp_width(int'(width_reg));
    at_end = (col_pos >= w - 1);
    blank = '0;
    fresh = '0;
    if (col_pos < MAX_WIDTH) begin
      if (row_pos >= 2) fresh.top = line_prev2[col_pos];
      if (row_pos >= 1) fresh.mid = line_prev1[col_pos];
    end
    fresh.bot = p;
    if (col_pos == 0) begin
      foreach (window[i]) window[i] = '0;
    end
    window[0] = window[1];
    window[1] = window[2];
    window[2] = fresh;
    if (row_pos >= 1 && col_pos >= 1) begin
      res.value = kernel_total(window[0], window[1], window[2]);
      res.run_end = !at_end;
      res.frame_done = 1'b0;
      pending_edges.insert(pending_edges.size(), res);
      // right edge output, zero column beyond the frame
      if (at_end) begin
        res.value = kernel_total(window[1], window[2], blank);
        res.run_end = 1'b1;
        res.frame_done = (kind == OP_FLUSH);
        pending_edges.insert(pending_edges.size(), res);
      end
    end
    if (col_pos < MAX_WIDTH) begin
      line_prev2[col_pos] = fresh.mid;
      line_prev1[col_pos] = p;
    end
    if (at_end) begin
      col_pos = 0;
      if (kind == OP_FLUSH) row_pos = 0;
      else row_pos = (row_pos >= ROW_CAP) ? ROW_CAP : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endtask

  // predictor, monitor and transfer bookkeeping
  always @(posedge clk) begin
    edge_result_t due;
    if (rst) begin
      in_took <= 1'b0;
      quiet_cycles <= 0;
      col_pos = 0;
      row_pos = 0;
      width_reg = CFG_W'(WIDTH_RESET);
      foreach (window[i]) window[i] = '0;
    end else begin
      in_took <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (cfg_valid && cfg_ready) width_reg = frame_width;
      if (out_valid && out_ready) begin
        if (pending_edges.size() == 0) begin
          $display("%0t: result with none due, edge_value %0d last_of_run %0b frame_end %0b",
                   $time, edge_value, last_of_run, frame_end);
          mismatches++;
        end else begin
          due = pending_edges.pop_front();
          if (edge_value !== due.value) begin
            $display("%0t: edge_value expected %0d actual %0d", $time, due.value, edge_value);
            mismatches++;
          end
          if (last_of_run !== due.run_end) begin
            $display("%0t: last_of_run expected %0b actual %0b", $time, due.run_end,
                     last_of_run);
            mismatches++;
          end
          if (frame_end !== due.frame_done) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, due.frame_done,
                     frame_end);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_edges(op, pixel);
    end
  end

  // pixel driver
  always @(negedge clk) begin
    stream_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pixel_stream.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
        item = pixel_stream.pop_front();
        in_valid <= 1'b1;
        op <= item.is_flush;
        pixel <= item.pix;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink, with one long hold-off once squeeze is raised
  int squeeze_count = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (squeeze && squeeze_count < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      squeeze_count = squeeze_count + 1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // stimulus
  int gen_w = WIDTH_RESET;

  function automatic pixel_t pick_pixel(input int style);
    case (style)
      1: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
      2: return pixel_t'($urandom_range(15));
      3: return pixel_t'(240 + $urandom_range(15));
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  task automatic queue_item(input logic kind, input pixel_t pix);
    stream_item_t it;
    it.is_flush = kind;
    it.pix = pix;
    pixel_stream.insert(pixel_stream.size(), it);
    queued_items++;
  endtask

  // full rows of pixels; noise puts flush items anywhere but the row end
  task automatic queue_rows(input int count, input int n, input int style, input int noise);
    for (int r = 0; r < count; r++) begin
      for (int c = 0; c < n; c++) begin
        if (c != n - 1 && $urandom_range(99) < noise) begin
          queue_item(OP_FLUSH, pixel_t'($urandom_range(255)));
        end else begin
          queue_item(OP_PIXEL, pick_pixel(style));
        end
      end
    end
  endtask

  // closing row; noise mixes pixels in before the final flush
  task automatic queue_flush_row(input int n, input int noise);
    for (int c = 0; c < n; c++) begin
      if (c != n - 1 && $urandom_range(99) < noise) begin
        queue_item(OP_PIXEL, pixel_t'($urandom_range(255)));
      end else begin
        queue_item(OP_FLUSH, pixel_t'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (pixel_stream.size() != 0 || in_valid || pending_edges.size() != 0) begin
      @(posedge clk);
    end
    // items on row 0 produce nothing, let them drain out of the pipeline
    repeat (8) @(posedge clk);
  endtask

  task automatic set_width(input int value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    frame_width <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_w = clamp_width(value);
  endtask

  initial begin
    int base;
    int frame_no;
    int w_req;
    int rows;
    int style;
    int noise;
    int tail_noise;
    int part;
    int pick;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset width, one row
    queue_rows(1, gen_w, 0, 0);
    queue_flush_row(gen_w, 0);

    // directed frames at the narrowest width (written below range)
    set_width(0);
    queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'hFF);
    queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'h00);
    queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'h00); queue_item(OP_PIXEL, 8'hFF);
    queue_flush_row(3, 0);
    // flush row straight after a frame end: no output, counters cleared
    queue_flush_row(3, 0);
    // mixed row: flush at column 0 acts as a zero pixel
    queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'hFF);
    queue_item(OP_FLUSH, 8'hFF); queue_item(OP_PIXEL, 8'hFF); queue_item(OP_PIXEL, 8'h00);
    queue_flush_row(3, 0);

    // widest frame, written above range
    set_width(511);
    queue_rows(1, gen_w, 1, 0);
    queue_flush_row(gen_w, 0);

    // width shrunk mid-row past the current column, then shrunk ahead of it
    set_width(20);
    queue_rows(2, 20, 0, 0);
    queue_rows(1, 7, 0, 0);
    set_width(5);
    queue_rows(1, 1, 0, 0);
    queue_rows(2, 5, 0, 0);
    queue_flush_row(5, 0);
    set_width(12);
    queue_rows(1, 12, 0, 0);
    queue_rows(1, 3, 0, 0);
    set_width(8);
    queue_rows(1, 5, 0, 0);
    queue_rows(1, 8, 0, 0);
    queue_flush_row(8, 0);

    // tall narrow frame
    set_width(3);
    queue_rows(24, 3, 0, 0);
    queue_flush_row(3, 0);

    base = queued_items;
    frame_no = 0;
    while (queued_items - base < RANDOM_ITEMS) begin
      steady <= (frame_no >= 5 && frame_no < 10);
      if (frame_no == 4) begin
        w_req = 16;
        rows = 4;
      end else begin
        pick = $urandom_range(99);
        if (pick < 85) w_req = $urandom_range(16, 3);
        else if (pick < 95) w_req = $urandom_range(48, 17);
        else w_req = $urandom_range(2, 0);
        rows = $urandom_range(6, 0);
      end
      if (gen_w != clamp_width(w_req) || $urandom_range(3) == 0) set_width(w_req);
      if (frame_no == 4) squeeze <= 1'b1;
      style = $urandom_range(3, 0);
      noise = ($urandom_range(99) < 30) ? 5 : 0;
      tail_noise = ($urandom_range(99) < 30) ? 10 : 0;
      if (rows >= 1 && gen_w > 3 && $urandom_range(99) < 12) begin
        queue_rows(rows, gen_w, style, noise);
        part = $urandom_range(gen_w - 2, 0);
        queue_rows(1, part, style, noise);
        set_width($urandom_range(gen_w - 1, 3));
        queue_rows(1, (part >= gen_w - 1) ? 1 : gen_w - part, style, 0);
        queue_rows($urandom_range(2, 0), gen_w, style, noise);
      end else begin
        queue_rows(rows, gen_w, style, noise);
      end
      queue_flush_row(gen_w, tail_noise);
      frame_no++;
    end

    while (pixel_stream.size() != 0 || in_valid || pending_edges.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
